[rtl/bca_pkg.sv]
package bca_pkg;

  // Geometry of the allocator
  localparam int MAX_CHUNKS   = 1024;
  localparam int MAX_BLOCKS   = 16;
  localparam int HEADER_BYTES = 64;
  localparam int MIN_CLASS    = 8;
  localparam int MAX_CLASS    = 36;

  localparam int NCLS   = MAX_CLASS - MIN_CLASS + 1;
  localparam int IDX_W  = $clog2(NCLS);
  localparam int HW     = $clog2(MAX_CHUNKS);
  localparam int LW     = HW + 1;
  localparam int BLK_W  = $clog2(MAX_BLOCKS);
  localparam int CLS_W  = 6;
  localparam int OFF_W  = 36;
  localparam int SIZE_W = OFF_W + 2;
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);

  // Chunk status is kept in rows of 32 two-bit entries
  localparam int ROW_ENTRIES = 32;
  localparam int ENT_W       = $clog2(ROW_ENTRIES);
  localparam int ROWS        = MAX_CHUNKS / ROW_ENTRIES;
  localparam int ROW_AW      = $clog2(ROWS);
  localparam int ROW_W       = 2 * ROW_ENTRIES;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [LW-1:0] NIL = LW'(MAX_CHUNKS);

  localparam logic [CLS_W-1:0] INIT_CLASS_RST = 6'd24;
  localparam logic [CLS_W-1:0] MAX_CLASS_RST  = 6'd30;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_FREE   = 2'd1,
    ST_ACTIVE = 2'd2
  } chunk_st_t;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RSP_OK      = 2'd0,
    RSP_TOO_BIG = 2'd1,
    RSP_FULL    = 2'd2
  } rsp_status_t;

  // Register select is address bit 2
  localparam logic REG_INIT_CLASS = 1'b0;
  localparam logic REG_MAX_CLASS  = 1'b1;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [OFF_W-1:0] off;
    logic [CLS_W-1:0] cls;
  } loc_t;

endpackage

[rtl/bca_ram.sv]
module bca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/buddy_chunk_allocator.sv]
// Allocate walks the size classes upward and then splits; free merges level by
//   level, walking the free list at each level to find the buddy.
// Throughput: one item at a time; the sequencer and its single status and location
//   memories and its two link memories set the rate. Release-all also clears the status memory.
// Reset: synchronous; a clearing pass over the status memory follows.
module buddy_chunk_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    kind,
  input  logic [bca_pkg::OFF_W-1:0]     request_bytes,
  input  logic [bca_pkg::HW-1:0]        chunk_handle,
  input  logic                          retain_empty,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic [bca_pkg::HW-1:0]        handle_out,
  output logic [bca_pkg::BLK_W-1:0]     block_index,
  output logic [bca_pkg::OFF_W-1:0]     chunk_offset,
  output logic [bca_pkg::CLS_W-1:0]     chunk_class,
  output logic                          block_fetched,
  output logic [bca_pkg::CLS_W-1:0]     block_class,
  output logic                          block_released,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bca_pkg::PADDR_W-1:0]   paddr,
  input  logic [bca_pkg::PDATA_W-1:0]   pwdata,
  output logic [bca_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  import bca_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_DONE,
    S_A_CLS, S_A_SRCH, S_A_FETCH, S_A_NBLOC, S_A_SPLIT, S_A_SPLOC, S_A_SPGET,
    S_A_SPWRH, S_A_SPWRU, S_A_SPPT, S_A_SPDEC, S_A_FINST, S_A_FINLOC, S_A_FINOUT,
    S_F_ST, S_F_CHK, S_F_LOC, S_M_CHK, S_M_WALK, S_M_CMP, S_M_MERGE, S_M_SW2,
    S_M_SWAP, S_M_GROW, S_F_END,
    S_PT0, S_PT1, S_PH0, S_PH1, S_UL0, S_UL1, S_FU0, S_FU1, S_SW0, S_SW1
  } state_t;

  state_t state, ret_r;

  // Configuration
  logic [CLS_W-1:0] init_class, max_class, next_bsc;
  logic [CLS_W-1:0] eff_init, eff_max;

  // List heads and tails, block table, row summary
  logic [LW-1:0]    head_q [NCLS];
  logic [LW-1:0]    tail_q [NCLS];
  logic             blk_valid [MAX_BLOCKS];
  logic [CLS_W-1:0] blk_cls [MAX_BLOCKS];
  logic [ROWS-1:0]  summary_q;
  logic [CNT_W-1:0] used_q;
  logic [ROW_AW-1:0] clr_row;
  logic             clr_emit;

  // Working registers
  logic [SIZE_W-1:0] size_r;
  logic [CLS_W-1:0]  cls_r, k_r, lcls_r, bcls_r;
  logic [HW-1:0]     ah_r, h_r, u_r;
  logic [LW-1:0]     j_r;
  logic [IDX_W-1:0]  li_r;
  logic [BLK_W-1:0]  blk_r;
  logic [OFF_W-1:0]  off_r, bo_r;
  logic              retain_r;
  chunk_st_t         sw_val_r;
  logic [ROW_AW-1:0] fu_row_r;

  // Pending result
  rsp_status_t       res_status;
  logic [HW-1:0]     res_handle;
  logic [BLK_W-1:0]  res_block;
  logic [OFF_W-1:0]  res_offset;
  logic [CLS_W-1:0]  res_class;
  logic              res_fetched;
  logic [CLS_W-1:0]  res_bclass;
  logic              res_released;

  // Memory ports
  logic              st_we;
  logic [ROW_AW-1:0] st_waddr, st_raddr;
  logic [ROW_W-1:0]  st_wdata, st_rdata;
  logic              loc_we;
  logic [HW-1:0]     loc_waddr, loc_raddr;
  loc_t              loc_wdata, loc_rdata;
  logic [$bits(loc_t)-1:0] loc_rbits;
  logic              prv_we, nxt_we;
  logic [HW-1:0]     prv_waddr, prv_raddr, nxt_waddr, nxt_raddr;
  logic [LW-1:0]     prv_wdata, prv_rdata, nxt_wdata, nxt_rdata;

  // Helpers
  logic [IDX_W-1:0]  list_idx;
  logic [LW-1:0]     hd, tl;
  logic [ROW_AW-1:0] fu_row;
  logic [ENT_W-1:0]  fu_ent, wr_ent;
  logic [ROW_W-1:0]  row_new;
  chunk_st_t         old_st;
  logic              new_any_unused;
  logic [CLS_W-1:0]  base_cls, nb_cls, base_inc;
  logic [BLK_W-1:0]  fb;
  logic              fb_ok;
  logic [CNT_W:0]    need_split, need_fetch;
  logic [SIZE_W-1:0] pow_cls;
  logic              cfg_wr;

  assign loc_rdata = loc_t'(loc_rbits);
  assign req_stall = (state != S_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_MAX_CLASS) ? PDATA_W'(max_class) : PDATA_W'(init_class);

  // Clamp the configured classes
  always_comb begin
    eff_init = init_class;
    if (init_class < CLS_W'(MIN_CLASS)) eff_init = CLS_W'(MIN_CLASS);
    if (init_class > CLS_W'(MAX_CLASS)) eff_init = CLS_W'(MAX_CLASS);
    eff_max = max_class;
    if (max_class < eff_init) eff_max = eff_init;
    if (max_class > CLS_W'(MAX_CLASS)) eff_max = CLS_W'(MAX_CLASS);
  end

  // New block sizing and slot search
  always_comb begin
    base_cls = next_bsc;
    if (base_cls < eff_init) base_cls = eff_init;
    if (base_cls > eff_max) base_cls = eff_max;
    nb_cls   = (base_cls < cls_r) ? cls_r : base_cls;
    base_inc = (base_cls + 1'b1 > eff_max) ? eff_max : base_cls + 1'b1;
    fb    = '0;
    fb_ok = 1'b0;
    for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
      if (!blk_valid[b]) begin
        fb    = BLK_W'(b);
        fb_ok = 1'b1;
      end
    end
    need_split = (CNT_W+1)'(used_q) + (CNT_W+1)'(k_r - cls_r);
    need_fetch = (CNT_W+1)'(used_q) + (CNT_W+1)'(nb_cls - cls_r) + 1'b1;
    pow_cls    = SIZE_W'(1) << cls_r;
  end

  // Pick the free list in use
  always_comb begin
    case (state)
      S_A_SRCH, S_A_SPLIT: list_idx = IDX_W'(k_r - CLS_W'(MIN_CLASS));
      S_M_CHK:             list_idx = IDX_W'(lcls_r - CLS_W'(MIN_CLASS));
      default:             list_idx = li_r;
    endcase
    hd = head_q[list_idx];
    tl = tail_q[list_idx];
  end

  // Find lowest row and entry with an unused slot; build the modified row
  always_comb begin
    fu_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (summary_q[r]) fu_row = ROW_AW'(r);
    end
    fu_ent = '0;
    for (int e = ROW_ENTRIES - 1; e >= 0; e--) begin
      if (st_rdata[2*e +: 2] == ST_UNUSED) fu_ent = ENT_W'(e);
    end
    wr_ent = (state == S_FU1) ? fu_ent : ah_r[ENT_W-1:0];
    old_st = chunk_st_t'(st_rdata[{wr_ent, 1'b0} +: 2]);
    new_any_unused = 1'b0;
    for (int e = 0; e < ROW_ENTRIES; e++) begin
      row_new[2*e +: 2] = (ENT_W'(e) == wr_ent) ? sw_val_r : st_rdata[2*e +: 2];
      if (row_new[2*e +: 2] == ST_UNUSED) new_any_unused = 1'b1;
    end
  end

  // Drive memory ports from the sequencer
  always_comb begin
    st_we = 1'b0;  st_waddr = '0;  st_wdata = '0;  st_raddr = '0;
    loc_we = 1'b0; loc_waddr = '0; loc_wdata = '0; loc_raddr = '0;
    prv_we = 1'b0; prv_waddr = '0; prv_wdata = '0; prv_raddr = '0;
    nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = '0; nxt_raddr = '0;
    case (state)
      S_CLEAR: begin
        st_we = 1'b1; st_waddr = clr_row;
      end
      S_F_ST, S_SW0: st_raddr = ah_r[HW-1:ENT_W];
      S_F_CHK: loc_raddr = h_r;
      S_FU0: st_raddr = fu_row;
      S_FU1: begin
        st_we = 1'b1; st_waddr = fu_row_r; st_wdata = row_new;
      end
      S_SW1: begin
        st_we = 1'b1; st_waddr = ah_r[HW-1:ENT_W]; st_wdata = row_new;
      end
      S_A_NBLOC: begin
        loc_we = 1'b1; loc_waddr = u_r; loc_wdata = '{blk: blk_r, off: '0, cls: k_r};
      end
      S_A_SPLOC, S_A_FINLOC: loc_raddr = h_r;
      S_A_SPWRH: begin
        loc_we = 1'b1; loc_waddr = h_r;
        loc_wdata = '{blk: blk_r, off: off_r, cls: k_r - 1'b1};
      end
      S_A_SPWRU: begin
        loc_we = 1'b1; loc_waddr = u_r;
        loc_wdata = '{blk: blk_r, off: off_r + (OFF_W'(1) << (k_r - 1'b1)),
                      cls: k_r - 1'b1};
      end
      S_M_WALK: begin
        loc_raddr = j_r[HW-1:0]; nxt_raddr = j_r[HW-1:0];
      end
      S_M_GROW: begin
        loc_we = 1'b1; loc_waddr = h_r;
        loc_wdata = '{blk: blk_r, off: off_r, cls: lcls_r + 1'b1};
      end
      S_PT0: begin
        prv_we = 1'b1; prv_waddr = ah_r; prv_wdata = tl;
        nxt_we = 1'b1; nxt_waddr = ah_r; nxt_wdata = NIL;
      end
      S_PT1: begin
        nxt_we = 1'b1; nxt_waddr = tl[HW-1:0]; nxt_wdata = LW'(ah_r);
      end
      S_PH0: begin
        prv_we = 1'b1; prv_waddr = ah_r; prv_wdata = NIL;
        nxt_we = 1'b1; nxt_waddr = ah_r; nxt_wdata = hd;
      end
      S_PH1: begin
        prv_we = 1'b1; prv_waddr = hd[HW-1:0]; prv_wdata = LW'(ah_r);
      end
      S_UL0: begin
        prv_raddr = ah_r; nxt_raddr = ah_r;
      end
      S_UL1: begin
        nxt_we = (prv_rdata != NIL); nxt_waddr = prv_rdata[HW-1:0]; nxt_wdata = nxt_rdata;
        prv_we = (nxt_rdata != NIL); prv_waddr = nxt_rdata[HW-1:0]; prv_wdata = prv_rdata;
      end
      default: ;
    endcase
  end

  // Sequencer, tables and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_row    <= '0;
      clr_emit   <= 1'b0;
      summary_q  <= '1;
      used_q     <= '0;
      rsp_valid  <= 1'b0;
      init_class <= INIT_CLASS_RST;
      max_class  <= MAX_CLASS_RST;
      next_bsc   <= INIT_CLASS_RST;
      for (int i = 0; i < NCLS; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        blk_valid[b] <= 1'b0;
      end
    end else begin
      // Drop a delivered beat
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_AW'(ROWS - 1)) begin
            state <= clr_emit ? S_DONE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            res_status   <= RSP_OK;
            res_handle   <= '0;
            res_block    <= '0;
            res_offset   <= '0;
            res_class    <= '0;
            res_fetched  <= 1'b0;
            res_bclass   <= '0;
            res_released <= 1'b0;
            size_r   <= (SIZE_W'(request_bytes) + SIZE_W'(HEADER_BYTES + 11)) & ~SIZE_W'(7);
            cls_r    <= CLS_W'(MIN_CLASS);
            ah_r     <= chunk_handle;
            h_r      <= chunk_handle;
            retain_r <= retain_empty;
            case (kind)
              KIND_ALLOC: state <= S_A_CLS;
              KIND_FREE:  state <= S_F_ST;
              KIND_RELEASE: begin
                for (int i = 0; i < NCLS; i++) begin
                  head_q[i] <= NIL;
                  tail_q[i] <= NIL;
                end
                for (int b = 0; b < MAX_BLOCKS; b++) begin
                  blk_valid[b] <= 1'b0;
                end
                next_bsc  <= eff_init;
                summary_q <= '1;
                used_q    <= '0;
                clr_row   <= '0;
                clr_emit  <= 1'b1;
                state     <= S_CLEAR;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            status         <= res_status;
            handle_out     <= res_handle;
            block_index    <= res_block;
            chunk_offset   <= res_offset;
            chunk_class    <= res_class;
            block_fetched  <= res_fetched;
            block_class    <= res_bclass;
            block_released <= res_released;
            state          <= S_IDLE;
          end
        end

        // Round the request up to its size class
        S_A_CLS: begin
          if (cls_r <= CLS_W'(MAX_CLASS) && pow_cls < size_r) begin
            cls_r <= cls_r + 1'b1;
          end else if (cls_r > eff_max) begin
            res_status <= RSP_TOO_BIG;
            state      <= S_DONE;
          end else begin
            k_r   <= cls_r;
            state <= S_A_SRCH;
          end
        end

        // Look for the smallest non-empty list at or above the class
        S_A_SRCH: begin
          if (hd != NIL) begin
            if (need_split > (CNT_W+1)'(MAX_CHUNKS)) begin
              res_status <= RSP_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_A_SPLIT;
            end
          end else if (k_r == CLS_W'(MAX_CLASS)) begin
            state <= S_A_FETCH;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end

        // Take a new block from backing store
        S_A_FETCH: begin
          if (!fb_ok || need_fetch > (CNT_W+1)'(MAX_CHUNKS)) begin
            res_status <= RSP_FULL;
            state      <= S_DONE;
          end else begin
            blk_valid[fb] <= 1'b1;
            blk_cls[fb]   <= nb_cls;
            blk_r         <= fb;
            res_fetched   <= 1'b1;
            res_bclass    <= nb_cls;
            next_bsc      <= base_inc;
            k_r           <= nb_cls;
            sw_val_r      <= ST_FREE;
            ret_r         <= S_A_NBLOC;
            state         <= S_FU0;
          end
        end

        S_A_NBLOC: begin
          li_r  <= IDX_W'(k_r - CLS_W'(MIN_CLASS));
          ah_r  <= u_r;
          ret_r <= S_A_SPLIT;
          state <= S_PT0;
        end

        // Split one level, or pop the granted chunk at the request class
        S_A_SPLIT: begin
          li_r  <= list_idx;
          ah_r  <= hd[HW-1:0];
          h_r   <= hd[HW-1:0];
          ret_r <= (k_r > cls_r) ? S_A_SPLOC : S_A_FINST;
          state <= S_UL0;
        end

        S_A_SPLOC: state <= S_A_SPGET;

        S_A_SPGET: begin
          blk_r    <= loc_rdata.blk;
          off_r    <= loc_rdata.off;
          sw_val_r <= ST_FREE;
          ret_r    <= S_A_SPWRH;
          state    <= S_FU0;
        end

        S_A_SPWRH: state <= S_A_SPWRU;

        S_A_SPWRU: begin
          li_r  <= IDX_W'(k_r - CLS_W'(MIN_CLASS + 1));
          ah_r  <= h_r;
          ret_r <= S_A_SPPT;
          state <= S_PT0;
        end

        S_A_SPPT: begin
          ah_r  <= u_r;
          ret_r <= S_A_SPDEC;
          state <= S_PT0;
        end

        S_A_SPDEC: begin
          k_r   <= k_r - 1'b1;
          state <= S_A_SPLIT;
        end

        S_A_FINST: begin
          sw_val_r <= ST_ACTIVE;
          ret_r    <= S_A_FINLOC;
          state    <= S_SW0;
        end

        S_A_FINLOC: state <= S_A_FINOUT;

        S_A_FINOUT: begin
          res_handle <= h_r;
          res_block  <= loc_rdata.blk;
          res_offset <= loc_rdata.off;
          res_class  <= cls_r;
          state      <= S_DONE;
        end

        // Free: check the chunk is granted
        S_F_ST: state <= S_F_CHK;

        S_F_CHK: begin
          state <= (old_st == ST_ACTIVE) ? S_F_LOC : S_DONE;
        end

        S_F_LOC: begin
          blk_r  <= loc_rdata.blk;
          off_r  <= loc_rdata.off;
          lcls_r <= loc_rdata.cls;
          bcls_r <= blk_cls[loc_rdata.blk];
          state  <= S_M_CHK;
        end

        // Merge with the buddy while one is free
        S_M_CHK: begin
          if (lcls_r < bcls_r) begin
            bo_r  <= off_r ^ (OFF_W'(1) << lcls_r);
            j_r   <= hd;
            li_r  <= list_idx;
            state <= S_M_WALK;
          end else begin
            state <= S_F_END;
          end
        end

        S_M_WALK: begin
          state <= (j_r == NIL) ? S_F_END : S_M_CMP;
        end

        S_M_CMP: begin
          if (loc_rdata.blk == blk_r && loc_rdata.cls == lcls_r && loc_rdata.off == bo_r) begin
            ah_r  <= j_r[HW-1:0];
            ret_r <= S_M_MERGE;
            state <= S_UL0;
          end else begin
            j_r   <= nxt_rdata;
            state <= S_M_WALK;
          end
        end

        S_M_MERGE: begin
          sw_val_r <= ST_UNUSED;
          state    <= S_SW0;
          if (bo_r < off_r) begin
            ah_r  <= h_r;
            ret_r <= S_M_SW2;
          end else begin
            ah_r  <= j_r[HW-1:0];
            ret_r <= S_M_GROW;
          end
        end

        S_M_SW2: begin
          ah_r     <= j_r[HW-1:0];
          sw_val_r <= ST_ACTIVE;
          ret_r    <= S_M_SWAP;
          state    <= S_SW0;
        end

        S_M_SWAP: begin
          h_r   <= j_r[HW-1:0];
          off_r <= bo_r;
          state <= S_M_GROW;
        end

        S_M_GROW: begin
          lcls_r <= lcls_r + 1'b1;
          state  <= S_M_CHK;
        end

        // Release the whole block or push the chunk at the list head
        S_F_END: begin
          res_block <= blk_r;
          res_class <= lcls_r;
          ah_r      <= h_r;
          li_r      <= IDX_W'(lcls_r - CLS_W'(MIN_CLASS));
          state     <= S_SW0;
          if (!retain_r && lcls_r == bcls_r) begin
            blk_valid[blk_r] <= 1'b0;
            blk_cls[blk_r]   <= '0;
            res_released     <= 1'b1;
            sw_val_r         <= ST_UNUSED;
            ret_r            <= S_DONE;
          end else begin
            sw_val_r <= ST_FREE;
            ret_r    <= S_PH0;
          end
        end

        // Push at tail
        S_PT0: begin
          if (tl == NIL) begin
            head_q[li_r] <= LW'(ah_r);
            tail_q[li_r] <= LW'(ah_r);
            state        <= ret_r;
          end else begin
            state <= S_PT1;
          end
        end

        S_PT1: begin
          tail_q[li_r] <= LW'(ah_r);
          state        <= ret_r;
        end

        // Push at head
        S_PH0: begin
          if (hd == NIL) begin
            head_q[li_r] <= LW'(ah_r);
            tail_q[li_r] <= LW'(ah_r);
            state        <= S_DONE;
          end else begin
            state <= S_PH1;
          end
        end

        S_PH1: begin
          head_q[li_r] <= LW'(ah_r);
          state        <= S_DONE;
        end

        // Unlink from its list
        S_UL0: state <= S_UL1;

        S_UL1: begin
          if (prv_rdata == NIL) head_q[li_r] <= nxt_rdata;
          if (nxt_rdata == NIL) tail_q[li_r] <= prv_rdata;
          state <= ret_r;
        end

        // Claim the lowest unused slot
        S_FU0: begin
          fu_row_r <= fu_row;
          state    <= S_FU1;
        end

        S_FU1: begin
          summary_q[fu_row_r] <= new_any_unused;
          used_q              <= used_q + 1'b1;
          u_r                 <= {fu_row_r, fu_ent};
          state               <= ret_r;
        end

        // Rewrite one slot status
        S_SW0: state <= S_SW1;

        S_SW1: begin
          summary_q[ah_r[HW-1:ENT_W]] <= new_any_unused;
          if (old_st == ST_UNUSED && sw_val_r != ST_UNUSED) begin
            used_q <= used_q + 1'b1;
          end else if (old_st != ST_UNUSED && sw_val_r == ST_UNUSED) begin
            used_q <= used_q - 1'b1;
          end
          state <= ret_r;
        end

        default: state <= S_IDLE;
      endcase

      // Register writes
      if (cfg_wr) begin
        if (paddr[2] == REG_INIT_CLASS) begin
          init_class <= pwdata[CLS_W-1:0];
          if (pwdata[CLS_W-1:0] < CLS_W'(MIN_CLASS)) begin
            next_bsc <= CLS_W'(MIN_CLASS);
          end else if (pwdata[CLS_W-1:0] > CLS_W'(MAX_CLASS)) begin
            next_bsc <= CLS_W'(MAX_CLASS);
          end else begin
            next_bsc <= pwdata[CLS_W-1:0];
          end
        end else begin
          max_class <= pwdata[CLS_W-1:0];
        end
      end
    end
  end

  bca_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_status_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  bca_ram #(.WIDTH($bits(loc_t)), .DEPTH(MAX_CHUNKS)) u_loc_ram (
    .clk(clk), .we(loc_we), .waddr(loc_waddr), .wdata(loc_wdata),
    .raddr(loc_raddr), .rdata(loc_rbits)
  );

  bca_ram #(.WIDTH(LW), .DEPTH(MAX_CHUNKS)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(prv_raddr), .rdata(prv_rdata)
  );

  bca_ram #(.WIDTH(LW), .DEPTH(MAX_CHUNKS)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_rdata)
  );

endmodule

[rtl/bca_checker.sv]
module bca_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic [1:0]                    kind,
  input logic [bca_pkg::OFF_W-1:0]     request_bytes,
  input logic [bca_pkg::HW-1:0]        chunk_handle,
  input logic                          retain_empty,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [1:0]                    status,
  input logic [bca_pkg::HW-1:0]        handle_out,
  input logic [bca_pkg::BLK_W-1:0]     block_index,
  input logic [bca_pkg::OFF_W-1:0]     chunk_offset,
  input logic [bca_pkg::CLS_W-1:0]     chunk_class,
  input logic                          block_fetched,
  input logic [bca_pkg::CLS_W-1:0]     block_class,
  input logic                          block_released,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [bca_pkg::PADDR_W-1:0]   paddr,
  input logic [bca_pkg::PDATA_W-1:0]   pwdata,
  input logic [bca_pkg::PDATA_W-1:0]   prdata,
  input logic                          pready
);

  import bca_pkg::*;

  // No beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(handle_out) &&
      $stable(chunk_offset) && $stable(block_index))
    else $error("stalled response changed");

  // Oversized request carries no handle, offset, class, fetch or release
  a_too_big: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == RSP_TOO_BIG |-> handle_out == '0 && chunk_offset == '0 &&
      chunk_class == '0 && !block_fetched && !block_released)
    else $error("oversized request reported a grant");

  // A release never comes with a grant
  a_release: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && block_released |-> status == RSP_OK && !block_fetched && handle_out == '0)
    else $error("release mixed with grant");

  // Fetched block covers the granted chunk
  a_fetch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && block_fetched |-> status == RSP_OK && block_class >= chunk_class)
    else $error("fetched block smaller than chunk");

endmodule

bind buddy_chunk_allocator bca_checker u_bca_checker (.*);
